@@ hw/rtl/polyphase_sinc_interpolator_macros.svh @@
// Assertion macros shared by the interpolator modules.
`ifndef POLYPHASE_SINC_INTERPOLATOR_MACROS_SVH
`define POLYPHASE_SINC_INTERPOLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/psi_pkg.sv @@
// Types, constants and kernel coefficient functions of the sinc interpolator.
package psi_pkg;

  // Default build values of the top-level parameters.
  localparam int LINE_MAX_DEF   = 1024;
  localparam int TAPS_DEF       = 8;
  localparam int OVERSAMPLE_DEF = 16;

  // Field widths.
  localparam int IDX_W    = 10;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int SHIFT_W  = 16;
  localparam int DATA_W   = 2 * SAMPLE_W;
  localparam int FRAC_W   = 8;
  localparam int T_W      = IDX_W + FRAC_W + 2;
  localparam int FL_W     = T_W - FRAC_W;
  // Wide enough for the largest oversampling factor of 64.
  localparam int PHASE_W  = 7;
  localparam int LEN_W    = 11;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

  // Command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Queue depths.
  localparam int OPQ_DEPTH  = 2;
  localparam int RESQ_DEPTH = 2;

  // Output rounding: Q3.29 accumulator down to Q1.15.
  localparam int RND_SHIFT  = 14;
  localparam int RND_HALF   = 8192;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // Fixed-point constants of the kernel build.
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint PI_Q30  = 64'sd3373259426;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN
  } psi_bk_state_e;

  // Decoded word passed from the front end to the datapath.
  typedef struct packed {
    logic                     is_query;
    logic [IDX_W-1:0]         addr;
    logic [DATA_W-1:0]        data;
    logic signed [FL_W-1:0]   fl;
    logic [PHASE_W-1:0]       phase;
  } psi_op_t;

  // Result word.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic                       sat;
  } psi_res_t;

  // Restoring unsigned division, evaluated only while building the kernel table.
  function automatic longint unsigned psi_udiv(input longint unsigned a,
                                               input longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned psi_umod(input longint unsigned a,
                                               input longint unsigned b);
    return a - psi_udiv(a, b) * b;
  endfunction

  // Signed division truncating towards zero.
  function automatic longint psi_sdiv(input longint a, input longint b);
    longint unsigned ua;
    longint unsigned ub;
    longint          q;
    logic            ng;
    ng = (a < 0) ^ (b < 0);
    ua = (a < 0) ? longint'(-a) : a;
    ub = (b < 0) ? longint'(-b) : b;
    q  = longint'(psi_udiv(ua, ub));
    return ng ? -q : q;
  endfunction

  // Division rounded half away from zero.
  function automatic longint psi_div_round(input longint a, input longint b);
    longint an;
    longint bn;
    an = a;
    bn = b;
    if (bn < 0) begin
      an = -an;
      bn = -bn;
    end
    if (an >= 0) begin
      return longint'(psi_udiv(an + (bn >>> 1), bn));
    end
    return -longint'(psi_udiv(-an + (bn >>> 1), bn));
  endfunction

  // sin(pi * num / den) in Q30 through a quarter-wave Taylor series.
  function automatic longint psi_sin_pi(input longint num, input longint den);
    longint          twod;
    longint          r;
    longint          acc;
    longint unsigned u;
    longint unsigned u2;
    longint unsigned term;
    logic            ng;
    twod = 2 * den;
    if (num >= 0) begin
      r = longint'(psi_umod(num, twod));
    end else begin
      r = twod - longint'(psi_umod(-num, twod));
      if (r == twod) r = 0;
    end
    ng = 1'b0;
    if (r >= den) begin
      r  = r - den;
      ng = 1'b1;
    end
    if (2 * r > den) r = den - r;
    u    = psi_udiv(r * PI_Q30, den);
    u2   = (u * u) >> 30;
    term = u;
    acc  = longint'(u);
    for (int n = 1; n <= 5; n++) begin
      term = psi_udiv((term * u2) >> 30, longint'((2 * n) * (2 * n + 1)));
      if (n % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    if (acc < 0)       acc = 0;
    if (acc > Q30_ONE) acc = Q30_ONE;
    return ng ? -acc : acc;
  endfunction

  // Windowed sinc value of one tap of one phase before normalisation.
  function automatic longint psi_kernel_val(input int p, input int k,
                                            input int taps, input int os);
    longint m;
    longint x;
    longint sn;
    longint w;
    longint s;
    longint d;
    longint c;
    m = longint'(k) - longint'(taps >>> 1) + 1;
    x = m * os - p;
    if (x == 0) begin
      sn = Q30_ONE;
    end else if (p == 0 || p == os) begin
      sn = 0;
    end else begin
      s  = psi_sin_pi(x, os);
      d  = psi_sdiv(PI_Q30 * x, os);
      sn = psi_sdiv(s * Q30_ONE, d);
    end
    if (taps >= 4) begin
      c = psi_sin_pi(4 * longint'(k) + (taps - 1), 2 * longint'(taps - 1));
      w = psi_sdiv(Q30_ONE - c, 2);
    end else begin
      w = Q30_ONE;
    end
    return psi_sdiv(sn * w, Q30_ONE);
  endfunction

  // Normalised Q2.14 coefficient of one tap of one phase.
  function automatic logic signed [COEF_W-1:0] psi_kernel_coef(input int p, input int k,
                                                               input int taps,
                                                               input int os);
    longint sum;
    longint v;
    longint c;
    sum = 0;
    for (int j = 0; j < taps; j++) begin
      sum = sum + psi_kernel_val(p, j, taps, os);
    end
    v = psi_kernel_val(p, k, taps, os);
    if (sum != 0) c = psi_div_round(v * 16384, sum);
    else          c = psi_div_round(v, 65536);
    if (c > SAMPLE_MAX) c = SAMPLE_MAX;
    if (c < SAMPLE_MIN) c = SAMPLE_MIN;
    return COEF_W'(c);
  endfunction

endpackage

@@ hw/rtl/psi_fifo.sv @@
// Small first-in first-out queue of words of any type.
`include "polyphase_sinc_interpolator_macros.svh"

module psi_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entries_q[rd_ptr_q];

  // Pointer and fill-count update; callers never push when full or pop when empty.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Word storage.
  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wr_ptr_q] <= data_i;
  end

  `PSI_ASSERT_SAME(a_no_overflow, push_i, !full_o || pop_i, "word pushed into a full queue")
  `PSI_ASSERT_SAME(a_no_underflow, pop_i, !empty_o, "word popped from an empty queue")
  `PSI_ASSERT_SAME(a_count_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "fill count beyond queue depth")

endmodule

@@ hw/rtl/psi_front.sv @@
// Front end: accepts input words, drops stray loads and decodes queries.
module psi_front #(
  parameter int LINE_MAX   = psi_pkg::LINE_MAX_DEF,
  parameter int OVERSAMPLE = psi_pkg::OVERSAMPLE_DEF
) (
  input  logic                                  push_i,
  input  logic                                  full_i,
  input  logic                                  cmd_i,
  input  logic [psi_pkg::IDX_W-1:0]             sample_index_i,
  input  logic signed [psi_pkg::SAMPLE_W-1:0]   sample_re_i,
  input  logic signed [psi_pkg::SAMPLE_W-1:0]   sample_im_i,
  input  logic signed [psi_pkg::SHIFT_W-1:0]    shift_i,
  output logic                                  op_push_o,
  output psi_pkg::psi_op_t                      op_o
);

  import psi_pkg::*;

  localparam int PH_W = FRAC_W + PHASE_W + 1;

  logic [T_W-1:0]    target;
  logic [PH_W-1:0]   ph_sum;
  logic              keep_load;

  // Target position in Q.8: index times 256 plus the signed shift.
  assign target = {2'b00, sample_index_i, FRAC_W'(0)} + T_W'(shift_i);

  // Round the fraction to the nearest of the oversampled phases.
  assign ph_sum = PH_W'(target[FRAC_W-1:0]) * PH_W'(OVERSAMPLE) + PH_W'(1 << (FRAC_W - 1));

  // A load beyond the store is dropped.
  assign keep_load = (32'(sample_index_i) < 32'(LINE_MAX));

  assign op_push_o = push_i && !full_i && ((cmd_i == CMD_QUERY) || keep_load);

  // Decoded word.
  always_comb begin
    op_o.is_query = (cmd_i == CMD_QUERY);
    op_o.addr     = sample_index_i;
    op_o.data     = {sample_re_i, sample_im_i};
    op_o.fl       = target[T_W-1:FRAC_W];
    op_o.phase    = ph_sum[FRAC_W +: PHASE_W];
  end

endmodule

@@ hw/rtl/psi_back.sv @@
// Datapath: line store, kernel table and the tap-serial multiply-accumulate sequencer.
`include "polyphase_sinc_interpolator_macros.svh"

module psi_back #(
  parameter int LINE_MAX   = psi_pkg::LINE_MAX_DEF,
  parameter int TAPS       = psi_pkg::TAPS_DEF,
  parameter int OVERSAMPLE = psi_pkg::OVERSAMPLE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  psi_pkg::psi_op_t            op_i,
  input  logic                        op_empty_i,
  output logic                        op_pop_o,
  input  logic [psi_pkg::LEN_W-1:0]   line_len_i,
  input  logic                        res_full_i,
  output logic                        res_push_o,
  output psi_pkg::psi_res_t           res_o
);

  import psi_pkg::*;

  localparam int AW        = $clog2(LINE_MAX);
  localparam int TAP_W     = $clog2(TAPS);
  localparam int ROM_DEPTH = (OVERSAMPLE + 1) * TAPS;
  localparam int ROM_AW    = $clog2(ROM_DEPTH);
  localparam int PW        = ($clog2(LINE_MAX + 1) + 2 > FL_W + 1) ?
                             $clog2(LINE_MAX + 1) + 2 : FL_W + 1;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + $clog2(TAPS) + 1;
  localparam int SW        = ACC_W + 1;

  localparam logic signed [SW-1:0] POS_LIM = SW'(SAMPLE_MAX);
  localparam logic signed [SW-1:0] NEG_LIM = SW'(SAMPLE_MIN);

  // Kernel coefficient table, built at elaboration.
  logic signed [COEF_W-1:0] rom_w [ROM_DEPTH];

  for (genvar p = 0; p <= OVERSAMPLE; p++) begin : g_phase
    for (genvar k = 0; k < TAPS; k++) begin : g_tap
      localparam logic signed [COEF_W-1:0] Coef = psi_kernel_coef(p, k, TAPS, OVERSAMPLE);
      assign rom_w[p * TAPS + k] = Coef;
    end
  end

  logic [DATA_W-1:0]         mem_q [LINE_MAX];

  psi_bk_state_e             state_q, state_d;
  logic [TAP_W-1:0]          tap_q;
  logic signed [FL_W-1:0]    fl_q;
  logic [ROM_AW-1:0]         rom_base_q;
  logic                      s1_vld_q, s2_vld_q;
  logic                      rng_q;
  logic [DATA_W-1:0]         rd_q;
  logic signed [COEF_W-1:0]  coef_q;
  logic signed [PROD_W-1:0]  prod_re_q, prod_im_q;
  logic signed [ACC_W-1:0]   acc_re_q, acc_im_q;

  logic                      start_query;
  logic                      do_load;
  logic                      mem_we;
  logic                      issue;
  logic                      drained;
  logic                      last_tap;
  logic [PW-1:0]             pos;
  logic                      in_range;
  logic [ROM_AW-1:0]         rom_idx;
  logic signed [SAMPLE_W-1:0] smp_re, smp_im;
  logic signed [SW-1:0]      rsum_re, rsum_im;
  logic signed [SW-1:0]      rq_re, rq_im;

  assign start_query = !op_empty_i && op_i.is_query && !res_full_i;
  assign do_load     = !op_empty_i && !op_i.is_query;
  assign drained     = !s1_vld_q && !s2_vld_q;
  assign last_tap    = (tap_q == TAP_W'(TAPS - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (start_query) state_d = BK_RUN;
      BK_RUN:   if (last_tap) state_d = BK_DRAIN;
      BK_DRAIN: if (drained) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    op_pop_o   = 1'b0;
    mem_we     = 1'b0;
    issue      = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        op_pop_o = start_query || do_load;
        mem_we   = do_load;
      end
      BK_RUN: begin
        issue = 1'b1;
      end
      BK_DRAIN: begin
        res_push_o = drained;
      end
      default: begin
        op_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      tap_q    <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      if (issue) tap_q <= last_tap ? '0 : tap_q + 1'b1;
    end
  end

  // Tap position and its bounds check against the effective line length.
  assign pos      = PW'(fl_q) + PW'(tap_q) - PW'(TAPS / 2 - 1);
  assign in_range = !pos[PW-1] && (pos < PW'(line_len_i)) && (pos < PW'(LINE_MAX));
  assign rom_idx  = rom_base_q + ROM_AW'(tap_q);

  // Line store: one write port for loads, one registered read port for taps.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[AW'(op_i.addr)] <= op_i.data;
    if (issue)  rd_q <= mem_q[pos[AW-1:0]];
  end

  // Samples outside the line contribute zero.
  assign smp_re = rng_q ? rd_q[DATA_W-1:SAMPLE_W] : '0;
  assign smp_im = rng_q ? rd_q[SAMPLE_W-1:0]      : '0;

  // Query capture, coefficient fetch, multiply stage and accumulator.
  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE && start_query) begin
      fl_q       <= op_i.fl;
      rom_base_q <= ROM_AW'(32'(op_i.phase) * 32'(TAPS));
      acc_re_q   <= '0;
      acc_im_q   <= '0;
    end else if (s2_vld_q) begin
      acc_re_q <= acc_re_q + ACC_W'(prod_re_q);
      acc_im_q <= acc_im_q + ACC_W'(prod_im_q);
    end
    if (issue) begin
      rng_q  <= in_range;
      coef_q <= rom_w[rom_idx];
    end
    if (s1_vld_q) begin
      prod_re_q <= PROD_W'(smp_re) * PROD_W'(coef_q);
      prod_im_q <= PROD_W'(smp_im) * PROD_W'(coef_q);
    end
  end

  // Round half up at bit 14, then clip to sixteen bits.
  assign rsum_re = SW'(acc_re_q) + SW'(RND_HALF);
  assign rsum_im = SW'(acc_im_q) + SW'(RND_HALF);
  assign rq_re   = rsum_re >>> RND_SHIFT;
  assign rq_im   = rsum_im >>> RND_SHIFT;

  always_comb begin
    res_o.sat = 1'b0;
    if (rq_re > POS_LIM) begin
      res_o.re  = SAMPLE_W'(POS_LIM);
      res_o.sat = 1'b1;
    end else if (rq_re < NEG_LIM) begin
      res_o.re  = SAMPLE_W'(NEG_LIM);
      res_o.sat = 1'b1;
    end else begin
      res_o.re  = rq_re[SAMPLE_W-1:0];
    end
    if (rq_im > POS_LIM) begin
      res_o.im  = SAMPLE_W'(POS_LIM);
      res_o.sat = 1'b1;
    end else if (rq_im < NEG_LIM) begin
      res_o.im  = SAMPLE_W'(NEG_LIM);
      res_o.sat = 1'b1;
    end else begin
      res_o.im  = rq_im[SAMPLE_W-1:0];
    end
  end

  `PSI_ASSERT_NEXT(a_pipe_step, s1_vld_q, s2_vld_q, "multiply stage skipped a tap")
  `PSI_ASSERT_NEXT(a_run_ends, (state_q == BK_RUN) && last_tap, state_q == BK_DRAIN, "tap run overran")
  `PSI_ASSERT_SAME(a_push_space, res_push_o, !res_full_i, "result pushed without space")

endmodule

@@ hw/rtl/polyphase_sinc_interpolator.sv @@
// Top level of the polyphase windowed-sinc fractional-delay interpolator.
//
// Channel  Dir  Handshake              Word
// input    in   push / full            cmd, sample_index, sample_re, sample_im, shift
// result   out  pop / empty            out_re, out_im, saturated
// config   in   cfg_valid / cfg_ready  line_length (always ready)
//
// A load is written into the line store as it is popped; a query reads its taps through the
// single read port of the line store, which yields one tap per cycle.
// The input queue holds two words, so the front end keeps accepting while a query runs.
// A query starts only when the result queue has room, so a stalled reader halts the datapath.
// Reset empties both queues, idles the sequencer and sets line_length to 1024.
module polyphase_sinc_interpolator #(
  parameter int LINE_MAX   = psi_pkg::LINE_MAX_DEF,
  parameter int TAPS       = psi_pkg::TAPS_DEF,
  parameter int OVERSAMPLE = psi_pkg::OVERSAMPLE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                cmd_i,
  input  logic [psi_pkg::IDX_W-1:0]           sample_index_i,
  input  logic signed [psi_pkg::SAMPLE_W-1:0] sample_re_i,
  input  logic signed [psi_pkg::SAMPLE_W-1:0] sample_im_i,
  input  logic signed [psi_pkg::SHIFT_W-1:0]  shift_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [psi_pkg::SAMPLE_W-1:0] out_re_o,
  output logic signed [psi_pkg::SAMPLE_W-1:0] out_im_o,
  output logic                                saturated_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [psi_pkg::LEN_W-1:0]           cfg_data_i
);

  import psi_pkg::*;

  logic [LEN_W-1:0] line_len_q;
  logic             op_push;
  psi_op_t          op_in;
  psi_op_t          op_head;
  logic             op_empty;
  logic             op_pop;
  logic             res_push;
  logic             res_full;
  psi_res_t         res_in;
  psi_res_t         res_head;

  // Line length register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q <= LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      line_len_q <= cfg_data_i;
    end
  end

  // Front end decode.
  psi_front #(
    .LINE_MAX   (LINE_MAX),
    .OVERSAMPLE (OVERSAMPLE)
  ) u_front (
    .push_i         (push),
    .full_i         (full),
    .cmd_i          (cmd_i),
    .sample_index_i (sample_index_i),
    .sample_re_i    (sample_re_i),
    .sample_im_i    (sample_im_i),
    .shift_i        (shift_i),
    .op_push_o      (op_push),
    .op_o           (op_in)
  );

  // Queue of decoded words between front end and datapath.
  psi_fifo #(
    .T     (psi_op_t),
    .DEPTH (OPQ_DEPTH)
  ) u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  (op_in),
    .full_o  (full),
    .pop_i   (op_pop),
    .data_o  (op_head),
    .empty_o (op_empty)
  );

  // Datapath.
  psi_back #(
    .LINE_MAX   (LINE_MAX),
    .TAPS       (TAPS),
    .OVERSAMPLE (OVERSAMPLE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op_head),
    .op_empty_i (op_empty),
    .op_pop_o   (op_pop),
    .line_len_i (line_len_q),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // Result queue towards the reader.
  psi_fifo #(
    .T     (psi_res_t),
    .DEPTH (RESQ_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop && !empty),
    .data_o  (res_head),
    .empty_o (empty)
  );

  assign out_re_o    = res_head.re;
  assign out_im_o    = res_head.im;
  assign saturated_o = res_head.sat;

endmodule
